### hw/rtl/bmd_pkg.sv
// bmd_pkg: shared types and constants for the binary Morse decoder.
// Holds the fixed 36-entry pattern table, ASCII codes and register indexes.
// No dependencies; used by bmd_lookup and binary_morse_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

package bmd_pkg;

   // table geometry
   localparam int PAT_BITS    = 19;
   localparam int NUM_PAT     = 36;
   localparam int NUM_LETTERS = 26;

   // ascii codes
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_0     = 7'h30;
   localparam logic [6:0] CHAR_SPACE = 7'h20;

   // configuration register indexes
   localparam logic CSR_LETTER_GAP = 1'b0;
   localparam logic CSR_WORD_GAP   = 1'b1;

   // configuration reset values
   localparam logic [3:0] LETTER_GAP_RESET = 4'd3;
   localparam logic [3:0] WORD_GAP_RESET   = 4'd7;
   localparam logic [3:0] GAP_MAX          = 4'd15;

   // keying patterns, newest unit in bit 0, A-Z then 0-9
   localparam logic [PAT_BITS-1:0] TBL_PAT [NUM_PAT] = '{
      19'b10111, 19'b111010101, 19'b11101011101, 19'b1110101, 19'b1,
      19'b101011101, 19'b111011101, 19'b1010101, 19'b101, 19'b1011101110111,
      19'b111010111, 19'b101110101, 19'b1110111, 19'b11101, 19'b11101110111,
      19'b10111011101, 19'b1110111010111, 19'b1011101, 19'b10101, 19'b111,
      19'b1010111, 19'b101010111, 19'b101110111, 19'b11101010111,
      19'b1110101110111, 19'b11101110101,
      19'b1110111011101110111, 19'b10111011101110111, 19'b101011101110111,
      19'b1010101110111, 19'b10101010111, 19'b101010101, 19'b11101010101,
      19'b1110111010101, 19'b111011101110101, 19'b11101110111011101
   };

   // pattern lengths in units
   localparam logic [4:0] TBL_LEN [NUM_PAT] = '{
      5'd5, 5'd9, 5'd11, 5'd7, 5'd1,
      5'd9, 5'd9, 5'd7, 5'd3, 5'd13,
      5'd9, 5'd9, 5'd7, 5'd5, 5'd11,
      5'd11, 5'd13, 5'd7, 5'd5, 5'd3,
      5'd7, 5'd9, 5'd9, 5'd11, 5'd13,
      5'd11,
      5'd19, 5'd17, 5'd15, 5'd13, 5'd11, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17
   };

   // lookup outcome
   typedef struct packed {
      logic       hit;
      logic [6:0] character;
   } lookup_result_type;

   // results of one transaction, held as one buffer entry
   typedef struct packed {
      logic       two;
      logic [6:0] ch0;
      logic [6:0] ch1;
   } rsp_pair_type;

   // ascii code of table entry idx
   function automatic logic [6:0] pat_char(input logic [5:0] idx);
      logic [6:0] code;
      if (idx < 6'(NUM_LETTERS)) begin
         code = CHAR_A + 7'(idx);
      end else begin
         code = CHAR_0 + 7'(idx - 6'(NUM_LETTERS));
      end
      return code;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/binary_morse_decoder_core.sv
// binary_morse_decoder_core: decodes timed Morse keying units into ASCII.
// Depends on bmd_pkg and instantiates bmd_lookup twice.
//
// Usage: each req_ transaction carries one timing unit (req_key_bit, 1 mark,
// 0 space) and req_end_of_message on the final unit. Each rsp_ transaction
// carries one character ('A'-'Z', '0'-'9' or space); rsp_last_in_run marks
// the final character caused by one request. A request may cause 0, 1 or 2
// characters.
// A character is registered in the result buffer as its request is accepted.
// Throughput: one request per cycle when rsp_ready is high and each request
// yields at most one character; a two-character request holds its buffer
// entry until both are taken. The symbol state update and both table compares
// are done in the cycle of acceptance, in front of a two-entry result buffer.
// Stall: when rsp_ready is low, results queue in the buffer; req_ready
// falls once both entries are taken and rises as soon as one drains.
// Reset: letter_gap returns to 3, word_gap to 7, the symbol and gap count
// clear and the buffer empties. csr_ writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module binary_morse_decoder_core
   import bmd_pkg::*;
#(
   parameter int MAX_SYMBOL_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_key_bit,
   input  wire logic       req_end_of_message,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_character,
   output logic            rsp_last_in_run,
   // configuration write port
   input  wire logic       csr_write,
   input  wire logic       csr_index,
   input  wire logic [3:0] csr_data
);

   localparam int LW = $clog2(MAX_SYMBOL_BITS + 1);
   localparam logic [1:0] BUF_DEPTH = 2'd2;

   // configuration registers
   logic [3:0] letter_gap_ff, word_gap_ff;

   // symbol state
   logic [3:0]                 gap_count_ff, gap_count_in;
   logic [MAX_SYMBOL_BITS-1:0] sym_bits_ff, sym_bits_in;
   logic [LW-1:0]              sym_len_ff, sym_len_in;
   logic                       sym_ov_ff, sym_ov_in;

   // result buffer
   rsp_pair_type pair_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff, sel_ff;
   logic [1:0]   count_ff;

   // per-transaction datapath
   logic                       req_accept, rsp_accept;
   logic                       close_letter, close_word, closing;
   logic [MAX_SYMBOL_BITS-1:0] close_bits, post_bits;
   logic [LW-1:0]              close_len, post_len;
   logic [3:0]                 gap_sat;
   logic                       post_ov;
   lookup_result_type          close_res, eom_res;
   logic                       c0_v, c1_v, c2_v, any_v;
   rsp_pair_type               pair_new;
   rsp_pair_type               head;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;

   // gap decisions on a mark
   assign close_letter = req_key_bit && (letter_gap_ff != '0) &&
                         (gap_count_ff == letter_gap_ff);
   assign close_word   = req_key_bit && !close_letter && (word_gap_ff != '0) &&
                         (gap_count_ff == word_gap_ff);
   assign closing      = close_letter || close_word;

   // drop the trailing separator before the close lookup
   assign close_bits = sym_bits_ff >> 1;
   assign close_len  = (sym_len_ff != '0) ? sym_len_ff - LW'(1) : sym_len_ff;
   assign gap_sat    = (gap_count_ff == GAP_MAX) ? GAP_MAX : gap_count_ff + 4'd1;

   bmd_lookup #(.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)) u_close_lookup (
      .sym_bits    (close_bits),
      .sym_len     (close_len),
      .sym_overflow(sym_ov_ff),
      .result      (close_res)
   );

   // symbol after the unit is taken in
   always_comb begin
      post_bits = sym_bits_ff;
      post_len  = sym_len_ff;
      post_ov   = sym_ov_ff;
      if (req_key_bit && closing) begin
         post_bits = MAX_SYMBOL_BITS'(1);
         post_len  = LW'(1);
         post_ov   = 1'b0;
      end else if (req_key_bit || gap_sat == 4'd1) begin
         if (sym_len_ff == LW'(MAX_SYMBOL_BITS)) begin
            post_ov = 1'b1;
         end else begin
            post_bits = {sym_bits_ff[MAX_SYMBOL_BITS-2:0], req_key_bit};
            post_len  = sym_len_ff + LW'(1);
         end
      end
   end

   bmd_lookup #(.MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)) u_eom_lookup (
      .sym_bits    (post_bits),
      .sym_len     (post_len),
      .sym_overflow(post_ov),
      .result      (eom_res)
   );

   // next symbol state, flushed at end of message
   always_comb begin
      gap_count_in = req_key_bit ? 4'd0 : gap_sat;
      sym_bits_in  = post_bits;
      sym_len_in   = post_len;
      sym_ov_in    = post_ov;
      if (req_end_of_message) begin
         gap_count_in = 4'd0;
         sym_bits_in  = '0;
         sym_len_in   = '0;
         sym_ov_in    = 1'b0;
      end
   end

   // pick the first two of letter, space, flushed letter
   assign c0_v  = closing && close_res.hit;
   assign c1_v  = close_word;
   assign c2_v  = req_end_of_message && (post_len != '0) && eom_res.hit;
   assign any_v = c0_v || c1_v || c2_v;

   always_comb begin
      pair_new     = '0;
      pair_new.two = (c0_v && (c1_v || c2_v)) || (c1_v && c2_v);
      if (c0_v) begin
         pair_new.ch0 = close_res.character;
         pair_new.ch1 = c1_v ? CHAR_SPACE : eom_res.character;
      end else if (c1_v) begin
         pair_new.ch0 = CHAR_SPACE;
         pair_new.ch1 = eom_res.character;
      end else begin
         pair_new.ch0 = eom_res.character;
      end
   end

   // result buffer head
   assign head            = pair_ff[rd_ptr_ff];
   assign req_ready       = (count_ff != BUF_DEPTH);
   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_character   = sel_ff ? head.ch1 : head.ch0;
   assign rsp_last_in_run = head.two ? sel_ff : 1'b1;

   // configuration and symbol state
   always_ff @(posedge clock) begin
      if (reset) begin
         letter_gap_ff <= LETTER_GAP_RESET;
         word_gap_ff   <= WORD_GAP_RESET;
         gap_count_ff  <= '0;
         sym_bits_ff   <= '0;
         sym_len_ff    <= '0;
         sym_ov_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LETTER_GAP: letter_gap_ff <= csr_data;
               CSR_WORD_GAP:   word_gap_ff   <= csr_data;
               default:        letter_gap_ff <= letter_gap_ff;
            endcase
         end
         if (req_accept) begin
            gap_count_ff <= gap_count_in;
            sym_bits_ff  <= sym_bits_in;
            sym_len_ff   <= sym_len_in;
            sym_ov_ff    <= sym_ov_in;
         end
      end
   end

   // buffer payload
   always_ff @(posedge clock) begin
      if (req_accept && any_v) begin
         pair_ff[wr_ptr_ff] <= pair_new;
      end
   end

   // buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         sel_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         logic push, pop;
         push = req_accept && any_v;
         pop  = rsp_accept && (!head.two || sel_ff);
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (rsp_accept) begin
            sel_ff <= !pop;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // buffer never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff <= BUF_DEPTH)
      else $error("result buffer overfilled");

   // second half of an entry is only selected for a two-result entry
   assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (rsp_valid && head.two))
      else $error("second result selected without one");

   // end of message leaves an empty symbol and zero gap
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_of_message) |=>
         (sym_len_ff == '0 && gap_count_ff == 4'd0 && !sym_ov_ff))
      else $error("symbol not flushed at end of message");

   // symbol length bounded by its storage
   assert property (@(posedge clock) disable iff (reset)
      sym_len_ff <= LW'(MAX_SYMBOL_BITS))
      else $error("symbol length out of range");

endmodule

`default_nettype wire

### hw/rtl/bmd_lookup.sv
// bmd_lookup: matches a symbol pattern against the fixed Morse table.
// Depends on bmd_pkg for the table, the character codes and the result type.
`timescale 1ns / 1ps
`default_nettype none

module bmd_lookup
   import bmd_pkg::*;
#(
   parameter int MAX_SYMBOL_BITS = 32
) (
   input  wire logic [MAX_SYMBOL_BITS-1:0]         sym_bits,
   input  wire logic [$clog2(MAX_SYMBOL_BITS+1)-1:0] sym_len,
   input  wire logic                                sym_overflow,
   output lookup_result_type                        result
);

   localparam int LW = $clog2(MAX_SYMBOL_BITS + 1);

   // parallel compare against every entry; entries are unique
   always_comb begin
      result = '0;
      if (!sym_overflow) begin
         for (int i = 0; i < NUM_PAT; i++) begin
            if (sym_len == LW'(TBL_LEN[i]) &&
                sym_bits == MAX_SYMBOL_BITS'(TBL_PAT[i])) begin
               result.hit       = 1'b1;
               result.character = pat_char(6'(i));
            end
         end
      end
   end

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for binary_morse_decoder_core, with its own
// decoder model, directed keying cases, randomized messages and stalls.
// Depends on bmd_pkg for codes and register indexes, and on the core RTL.
`timescale 1ns / 1ps

module testbench;
   import bmd_pkg::*;

   localparam int SYMBOL_CAP = 32;

   // keying patterns, first unit leftmost, A-Z then 0-9
   string morse_table [NUM_PAT] = '{
      "10111", "111010101", "11101011101", "1110101", "1",
      "101011101", "111011101", "1010101", "101", "1011101110111",
      "111010111", "101110101", "1110111", "11101", "11101110111",
      "10111011101", "1110111010111", "1011101", "10101", "111",
      "1010111", "101010111", "101110111", "11101010111", "1110101110111",
      "11101110101",
      "1110111011101110111", "10111011101110111", "101011101110111",
      "1010101110111", "10101010111", "101010101", "11101010101",
      "1110111010101", "111011101110101", "11101110111011101"
   };

   // gap settings walked through by the random phases, extremes included
   logic [3:0] plan_letter_gap [8] = '{4'd3, 4'd1, 4'd15, 4'd0, 4'd4, 4'd5, 4'd2, 4'd1};
   logic [3:0] plan_word_gap   [8] = '{4'd7, 4'd15, 4'd1, 4'd5, 4'd0, 4'd5, 4'd6, 4'd3};

   typedef struct packed {
      logic [6:0] character;
      logic       last_in_run;
   } decoded_char_type;

   // dut signals
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_key_bit = 1'b0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_character;
   logic       rsp_last_in_run;
   logic       csr_write = 1'b0;
   logic       csr_index = CSR_LETTER_GAP;
   logic [3:0] csr_data = 4'd0;

   // decoder model state
   logic [3:0]            letter_gap_q = LETTER_GAP_RESET;
   logic [3:0]            word_gap_q = WORD_GAP_RESET;
   logic [3:0]            gap_run = 4'd0;
   logic [SYMBOL_CAP-1:0] symbol_q = '0;
   int unsigned           symbol_len = 0;
   logic                  symbol_ovf = 1'b0;
   decoded_char_type      expected_chars [$];

   // run control
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned ready_hold_cycles = 0;
   int unsigned error_count = 0;

   binary_morse_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_bit        (req_key_bit),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_character      (rsp_character),
      .rsp_last_in_run    (rsp_last_in_run),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // decoder model
   // ---------------------------------------------------------------

   function automatic void clear_symbol();
      symbol_q = '0;
      symbol_len = 0;
      symbol_ovf = 1'b0;
   endfunction

   // a bit that does not fit is lost and flags the symbol
   function automatic void append_symbol_bit(input logic b);
      if (symbol_len >= SYMBOL_CAP) begin
         symbol_ovf = 1'b1;
      end else begin
         symbol_q = {symbol_q[SYMBOL_CAP-2:0], b};
         symbol_len++;
      end
   endfunction

   // ascii code of the current symbol, or -1 when it matches nothing
   function automatic int match_symbol();
      string pat;
      logic  same;
      if (symbol_ovf || symbol_len == 0 || symbol_len > PAT_BITS) return -1;
      for (int idx = 0; idx < NUM_PAT; idx++) begin
         pat = morse_table[idx];
         if (pat.len() == symbol_len) begin
            same = 1'b1;
            for (int i = 0; i < pat.len(); i++) begin
               if ((pat[i] == "1") != symbol_q[symbol_len-1-i]) same = 1'b0;
            end
            if (same) begin
               if (idx < NUM_LETTERS) return CHAR_A + idx;
               return CHAR_0 + (idx - NUM_LETTERS);
            end
         end
      end
      return -1;
   endfunction

   // drop the separator zero, look the symbol up and start a fresh one
   function automatic int close_symbol();
      int code;
      if (symbol_len != 0) begin
         symbol_q = symbol_q >> 1;
         symbol_len--;
      end
      code = match_symbol();
      clear_symbol();
      return code;
   endfunction

   // expected characters for one accepted keying unit
   task automatic decode_unit(input logic key, input logic eom);
      int               codes [$];
      int               code;
      decoded_char_type ch;
      if (key) begin
         if (letter_gap_q != 4'd0 && gap_run == letter_gap_q) begin
            code = close_symbol();
            if (code >= 0) codes.push_back(code);
         end else if (word_gap_q != 4'd0 && gap_run == word_gap_q) begin
            code = close_symbol();
            if (code >= 0) codes.push_back(code);
            codes.push_back(CHAR_SPACE);
         end
         gap_run = 4'd0;
         append_symbol_bit(1'b1);
      end else begin
         if (gap_run != GAP_MAX) gap_run++;
         if (gap_run == 4'd1) append_symbol_bit(1'b0);
      end
      // flush on end of message, at most two characters per unit
      if (eom) begin
         if (symbol_len != 0) begin
            code = match_symbol();
            if (code >= 0 && codes.size() < 2) codes.push_back(code);
         end
         clear_symbol();
         gap_run = 4'd0;
      end
      foreach (codes[i]) begin
         ch.character = codes[i][6:0];
         ch.last_in_run = (i == codes.size() - 1);
         expected_chars.push_back(ch);
      end
   endtask

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // compare each result transaction with the oldest expected character
   always @(posedge clock) begin : check_rsp
      decoded_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_character, rsp_last_in_run));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, want.character));
            if (rsp_last_in_run !== want.last_in_run)
               report_mismatch($sformatf("last_in_run %0b, expected %0b for 0x%02h",
                                         rsp_last_in_run, want.last_in_run,
                                         want.character));
         end
      end
   end

   // receiver: random stalls, or a long hold-off while the counter runs
   initial begin
      forever begin
         @(negedge clock);
         if (ready_hold_cycles != 0) begin
            rsp_ready = 1'b0;
            ready_hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one request transaction; entered and left at a falling edge
   task automatic send_unit(input logic key, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_key_bit = key;
      req_end_of_message = eom;
      do @(posedge clock); while (!req_ready);
      decode_unit(key, eom);
      @(negedge clock);
   endtask

   // send a keying string, end of message on its last unit
   task automatic send_keying(input string units);
      for (int i = 0; i < units.len(); i++) begin
         send_unit(units[i] == "1", i == units.len() - 1);
      end
   endtask

   function automatic string unit_run(input logic key, input int unsigned count);
      string s;
      s = "";
      repeat (count) begin
         if (key) s = {s, "1"};
         else s = {s, "0"};
      end
      return s;
   endfunction

   // stop offering and let every expected character drain
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_gap_register(input logic index, input logic [3:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (index == CSR_LETTER_GAP) letter_gap_q = value;
      else word_gap_q = value;
   endtask

   task automatic set_gaps(input logic [3:0] letter_gap, input logic [3:0] word_gap);
      write_gap_register(CSR_LETTER_GAP, letter_gap);
      write_gap_register(CSR_WORD_GAP, word_gap);
   endtask

   // mostly well-formed letters and gaps, some noise and overlong runs
   function automatic string random_message();
      string       msg;
      int unsigned parts;
      int unsigned kind;
      int unsigned gap_pick;
      msg = "";
      parts = $urandom_range(8, 1);
      for (int k = 0; k < parts; k++) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            msg = {msg, morse_table[$urandom_range(NUM_PAT - 1)]};
            if (k != parts - 1 || $urandom_range(3) == 0) begin
               gap_pick = $urandom_range(99);
               if (gap_pick < 45) msg = {msg, unit_run(1'b0, letter_gap_q)};
               else if (gap_pick < 70) msg = {msg, unit_run(1'b0, word_gap_q)};
               else msg = {msg, unit_run(1'b0, $urandom_range(17))};
            end
         end else if (kind < 80) begin
            repeat ($urandom_range(8, 1))
               msg = {msg, unit_run(1'($urandom_range(1)), 1)};
         end else if (kind < 85) begin
            msg = {msg, unit_run(1'b1, $urandom_range(40, 20))};
         end else begin
            msg = {msg, unit_run(1'b0, $urandom_range(20))};
         end
      end
      if (msg.len() == 0) msg = "0";
      return msg;
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // default gaps: letter close, flush, word space, trailing zero, longest digit
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_keying({"1", unit_run(1'b0, 3), "111"});
      // word gap on the end unit: letter and space kept, flushed letter lost
      send_keying({"1", unit_run(1'b0, 7), "1"});
      send_keying("10");
      send_keying("0");
      send_keying(morse_table[NUM_LETTERS]);
      wait_for_results();
   endtask

   // saturating gap count, zero and equal gap registers, empty close
   task automatic test_gap_rules();
      set_gaps(4'd15, 4'd7);
      send_keying({"1", unit_run(1'b0, 20), "1"});
      wait_for_results();
      set_gaps(4'd0, 4'd0);
      send_keying({"1", unit_run(1'b0, 3), "1"});
      wait_for_results();
      set_gaps(4'd4, 4'd4);
      send_keying({"1", unit_run(1'b0, 4), "1"});
      wait_for_results();
      set_gaps(LETTER_GAP_RESET, WORD_GAP_RESET);
      send_keying({unit_run(1'b0, 3), "1"});
      send_keying("1111");
      wait_for_results();
   endtask

   // symbols longer than any pattern and longer than the symbol store
   task automatic test_overflow();
      send_keying({unit_run(1'b1, 40), unit_run(1'b0, 3), "1"});
      send_keying(unit_run(1'b1, 25));
      send_keying({unit_run(1'b1, SYMBOL_CAP), unit_run(1'b0, 3), "111"});
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int unsigned phase,
                                      input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned unit_budget);
      string       msg;
      int unsigned sent;
      int unsigned pick;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int round = 0; round < 4; round++) begin
         if (round < 3) begin
            pick = (phase * 3 + round) % 8;
            set_gaps(plan_letter_gap[pick], plan_word_gap[pick]);
         end else begin
            set_gaps(4'($urandom_range(15)), 4'($urandom_range(15)));
         end
         sent = 0;
         while (sent < unit_budget / 4) begin
            msg = random_message();
            send_keying(msg);
            sent += msg.len();
         end
         wait_for_results();
      end
   endtask

   // receiver holds off while a stream of letters fills the result buffer
   task automatic test_backpressure();
      string burst;
      burst = "";
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_gaps(4'd1, 4'd2);
      repeat (60) burst = {burst, "10"};
      ready_hold_cycles = 120;
      send_keying({burst, "1"});
      wait_for_results();
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_gap_rules();
      test_overflow();
      test_random_traffic(0, 12, 49, 220);
      test_random_traffic(1, 49, 12, 220);
      test_random_traffic(2, 0, 0, 220);
      test_backpressure();

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### binary_morse_decoder_core.f
hw/rtl/bmd_pkg.sv
hw/rtl/bmd_lookup.sv
hw/rtl/binary_morse_decoder_core.sv
tb/testbench.sv
